@@ design/csfu_pkg.sv @@
// Shared types and codes of the checked stack-frame unit.
// Holds the action, error and register index codes and the structs between modules.
// No dependencies.
package csfu_pkg;

    typedef enum logic [2:0] {
        ACT_PUSH       = 3'd0,
        ACT_POP        = 3'd1,
        ACT_READ_LOCAL = 3'd2,
        ACT_WRITE_LOCAL = 3'd3,
        ACT_SAVE_PC    = 3'd4,
        ACT_RESTORE_PC = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        ERR_OK       = 3'd0,
        ERR_OVERFLOW = 3'd1,
        ERR_UNDERFLOW = 3'd2,
        ERR_REUSE    = 3'd3,
        ERR_RANGE    = 3'd4
    } t_err;

    typedef enum logic [2:0] {
        CFG_FRAME_BASE   = 3'd0,
        CFG_OPERAND_BASE = 3'd1,
        CFG_STACK_END    = 3'd2,
        CFG_BOUND_CHECKS = 3'd3,
        CFG_REUSE_CHECKS = 3'd4
    } t_cfg_idx;

    localparam int unsigned CfgIdxBits  = 3;
    localparam int unsigned CfgDataBits = 9;
    localparam int unsigned InWordBits  = 16;
    localparam int unsigned PcBits      = 16;
    localparam int unsigned IndexBits   = 8;

    typedef struct packed {
        logic [7:0] frame_base;
        logic [8:0] operand_base;
        logic [8:0] stack_end;
        logic       bound_checks_on;
        logic       reuse_checks_on;
        logic       top_load;
    } t_cfg;

    typedef struct packed {
        logic                 rd_sel;
        logic                 rpc_sel;
        logic [IndexBits-1:0] slot_given;
        t_err                 error_code;
    } t_s1;

endpackage

@@ design/csfu_ram.sv @@
// Generic one-write, one-read memory with registered read data.
// Used for the word store and the return-address table; no package needed.
module csfu_ram #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8,
    parameter int unsigned DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/csfu_cfg.sv @@
// Configuration registers of the stack-frame unit.
// Depends on csfu_pkg for the register index codes and the t_cfg struct.
module csfu_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [csfu_pkg::CfgIdxBits-1:0]    i_cfg_idx,
    input  logic [csfu_pkg::CfgDataBits-1:0]   i_cfg_data,
    output csfu_pkg::t_cfg                     o_cfg
);

    logic [7:0] r_frame_base, n_frame_base;
    logic [8:0] r_operand_base, n_operand_base;
    logic [8:0] r_stack_end, n_stack_end;
    logic       r_bound_on, n_bound_on;
    logic       r_reuse_on, n_reuse_on;
    logic       top_load;

    always_comb begin
        n_frame_base   = r_frame_base;
        n_operand_base = r_operand_base;
        n_stack_end    = r_stack_end;
        n_bound_on     = r_bound_on;
        n_reuse_on     = r_reuse_on;
        top_load       = 1'b0;
        if (i_cfg_we) begin
            case (csfu_pkg::t_cfg_idx'(i_cfg_idx))
                csfu_pkg::CFG_FRAME_BASE: begin
                    n_frame_base = i_cfg_data[7:0];
                end
                csfu_pkg::CFG_OPERAND_BASE: begin
                    n_operand_base = i_cfg_data;
                    top_load       = 1'b1;
                end
                csfu_pkg::CFG_STACK_END: begin
                    n_stack_end = i_cfg_data;
                end
                csfu_pkg::CFG_BOUND_CHECKS: begin
                    n_bound_on = i_cfg_data[0];
                end
                csfu_pkg::CFG_REUSE_CHECKS: begin
                    n_reuse_on = i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_base   <= 8'd0;
            r_operand_base <= 9'd0;
            r_stack_end    <= 9'd256;
            r_bound_on     <= 1'b1;
            r_reuse_on     <= 1'b1;
        end else begin
            r_frame_base   <= n_frame_base;
            r_operand_base <= n_operand_base;
            r_stack_end    <= n_stack_end;
            r_bound_on     <= n_bound_on;
            r_reuse_on     <= n_reuse_on;
        end
    end

    // The new operand base goes out with the load flag so the stack top follows it.
    assign o_cfg.frame_base      = r_frame_base;
    assign o_cfg.operand_base    = top_load ? n_operand_base : r_operand_base;
    assign o_cfg.stack_end       = r_stack_end;
    assign o_cfg.bound_checks_on = r_bound_on;
    assign o_cfg.reuse_checks_on = r_reuse_on;
    assign o_cfg.top_load        = top_load;

endmodule

@@ design/csfu_ctrl.sv @@
// Decision logic, stack top, return count, used marks and first pipeline stage.
// Depends on csfu_pkg; drives the word store and return-address table ports.
module csfu_ctrl #(
    parameter int unsigned STORE_WORDS  = 256,
    parameter int unsigned RETURN_SLOTS = 16,
    parameter int unsigned WORD_BITS    = 16,
    parameter int unsigned ADDR_W       = 8,
    parameter int unsigned SLOT_AW      = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  csfu_pkg::t_cfg                      i_cfg,
    input  logic                                i_req_valid,
    output logic                                o_req_ready,
    input  logic [2:0]                          i_action,
    input  logic [csfu_pkg::InWordBits-1:0]     i_word_value,
    input  logic [csfu_pkg::IndexBits-1:0]      i_local_index,
    input  logic [csfu_pkg::PcBits-1:0]         i_current_pc,
    input  logic [csfu_pkg::IndexBits-1:0]      i_saved_slot,
    input  logic                                i_s1_adv,
    output logic                                o_s1_valid,
    output csfu_pkg::t_s1                       o_s1,
    output logic                                o_st_we,
    output logic [ADDR_W-1:0]                   o_st_waddr,
    output logic [WORD_BITS-1:0]                o_st_wdata,
    output logic                                o_st_re,
    output logic [ADDR_W-1:0]                   o_st_raddr,
    output logic                                o_rt_we,
    output logic [SLOT_AW-1:0]                  o_rt_waddr,
    output logic [csfu_pkg::PcBits-1:0]         o_rt_wdata,
    output logic                                o_rt_re,
    output logic [SLOT_AW-1:0]                  o_rt_raddr
);

    localparam int unsigned TOP_W = ADDR_W + 1;
    localparam int unsigned CMP_W = (TOP_W > 9) ? TOP_W + 1 : 10;
    localparam int unsigned CNT_W = $clog2(RETURN_SLOTS + 1);

    logic [TOP_W-1:0]        r_top, n_top;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [RETURN_SLOTS-1:0] r_used, n_used;
    logic                    r_s1_valid;
    csfu_pkg::t_s1           r_s1, n_s1;

    logic                    accept;
    logic [8:0]              loc;
    logic [CMP_W-1:0]        loc_w, top_w, end_w, ob_w;
    logic [TOP_W-1:0]        top_dec;
    logic                    loc_bad;
    logic                    slot_bad;
    logic                    table_full;
    logic [SLOT_AW-1:0]      slot_idx;
    logic [SLOT_AW-1:0]      count_idx;

    assign o_req_ready = !r_s1_valid || i_s1_adv;
    assign accept      = i_req_valid && o_req_ready;

    assign loc        = {1'b0, i_cfg.frame_base} + {1'b0, i_local_index};
    assign loc_w      = CMP_W'(loc);
    assign top_w      = CMP_W'(r_top);
    assign end_w      = CMP_W'(i_cfg.stack_end);
    assign ob_w       = CMP_W'(i_cfg.operand_base);
    assign top_dec    = r_top - TOP_W'(1);
    assign loc_bad    = i_cfg.bound_checks_on && (loc >= i_cfg.operand_base);
    assign slot_bad   = 9'(i_saved_slot) >= 9'(r_count);
    assign table_full = r_count >= CNT_W'(RETURN_SLOTS);
    assign slot_idx   = i_saved_slot[SLOT_AW-1:0];
    assign count_idx  = r_count[SLOT_AW-1:0];

    assign o_st_wdata = WORD_BITS'(i_word_value);
    assign o_rt_wdata = i_current_pc;
    assign o_rt_waddr = count_idx;
    assign o_rt_raddr = slot_idx;

    always_comb begin
        n_top      = r_top;
        n_count    = r_count;
        n_used     = r_used;
        n_s1       = r_s1;
        o_st_we    = 1'b0;
        o_st_re    = 1'b0;
        o_st_waddr = r_top[ADDR_W-1:0];
        o_st_raddr = top_dec[ADDR_W-1:0];
        o_rt_we    = 1'b0;
        o_rt_re    = 1'b0;
        if (accept) begin
            n_s1.rd_sel     = 1'b0;
            n_s1.rpc_sel    = 1'b0;
            n_s1.slot_given = '0;
            n_s1.error_code = csfu_pkg::ERR_OK;
            case (csfu_pkg::t_action'(i_action))
                csfu_pkg::ACT_PUSH: begin
                    if (i_cfg.bound_checks_on && top_w >= end_w) begin
                        n_s1.error_code = csfu_pkg::ERR_OVERFLOW;
                    end else begin
                        o_st_we = 1'b1;
                        n_top   = r_top + TOP_W'(1);
                    end
                end
                csfu_pkg::ACT_POP: begin
                    if (i_cfg.bound_checks_on && top_w <= ob_w) begin
                        n_s1.error_code = csfu_pkg::ERR_UNDERFLOW;
                    end else begin
                        o_st_re     = 1'b1;
                        n_s1.rd_sel = 1'b1;
                        n_top       = top_dec;
                    end
                end
                csfu_pkg::ACT_READ_LOCAL: begin
                    o_st_raddr = loc_w[ADDR_W-1:0];
                    if (loc_bad) begin
                        n_s1.error_code = csfu_pkg::ERR_OVERFLOW;
                    end else begin
                        o_st_re     = 1'b1;
                        n_s1.rd_sel = 1'b1;
                    end
                end
                csfu_pkg::ACT_WRITE_LOCAL: begin
                    o_st_waddr = loc_w[ADDR_W-1:0];
                    if (loc_bad) begin
                        n_s1.error_code = csfu_pkg::ERR_OVERFLOW;
                    end else begin
                        o_st_we = 1'b1;
                    end
                end
                csfu_pkg::ACT_SAVE_PC: begin
                    if (table_full) begin
                        n_s1.error_code = csfu_pkg::ERR_RANGE;
                    end else begin
                        o_rt_we             = 1'b1;
                        n_used[count_idx]   = 1'b0;
                        n_s1.slot_given     = 8'(r_count);
                        n_count             = r_count + CNT_W'(1);
                    end
                end
                csfu_pkg::ACT_RESTORE_PC: begin
                    if (slot_bad) begin
                        n_s1.error_code = csfu_pkg::ERR_RANGE;
                    end else if (i_cfg.reuse_checks_on && r_used[slot_idx]) begin
                        n_s1.error_code = csfu_pkg::ERR_REUSE;
                    end else begin
                        o_rt_re          = 1'b1;
                        n_used[slot_idx] = 1'b1;
                        n_s1.rpc_sel     = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_cfg.top_load) begin
            n_top = ob_w[TOP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top      <= '0;
            r_count    <= '0;
            r_used     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_top   <= n_top;
            r_count <= n_count;
            r_used  <= n_used;
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (i_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

endmodule

@@ design/csfu_out.sv @@
// Result register of the stack-frame unit and the master-side handshake.
// Depends on csfu_pkg for the stage struct and the field widths.
module csfu_out #(
    parameter int unsigned WORD_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s1_valid,
    input  csfu_pkg::t_s1                     i_s1,
    input  logic [WORD_BITS-1:0]              i_st_rdata,
    input  logic [csfu_pkg::PcBits-1:0]       i_rt_rdata,
    output logic                              o_s1_adv,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [47:0]                       o_data
);

    logic        r_valid;
    logic [47:0] r_data;
    logic [47:0] n_data;
    logic [15:0] read_word;
    logic [15:0] restored_pc;

    assign o_s1_adv    = i_s1_valid && (!r_valid || i_ready);
    assign read_word   = i_s1.rd_sel ? i_st_rdata[15:0] : 16'd0;
    assign restored_pc = i_s1.rpc_sel ? i_rt_rdata : 16'd0;
    assign n_data      = {5'd0, i_s1.error_code, i_s1.slot_given, restored_pc, read_word};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s1_adv) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s1_adv) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ design/checked_stack_frame_unit_core.sv @@
// Top level of the checked stack-frame unit: operand stack, locals and return table.
// Depends on csfu_pkg, csfu_cfg, csfu_ctrl, csfu_ram and csfu_out.
//
//  Channel      Direction  Payload
//  s_axis       in         tuser: action; tdata: word_value, local_index, current_pc, saved_slot
//  m_axis       out        tdata: read_word, restored_pc, slot_given, error_code
//  cfg          in         i_cfg_we, i_cfg_idx, i_cfg_data (write only)
//
// A request is taken every cycle unless m_axis back-pressure fills both registers. It passes
// the first-stage register, which lines up with the registered read port of the word store
// and return table, then the output register. A stalled result holds in the output register
// while one more request waits in the first stage; reset is synchronous, active low, no clearing pass.
module checked_stack_frame_unit_core #(
    parameter int unsigned STORE_WORDS  = 256,
    parameter int unsigned RETURN_SLOTS = 16,
    parameter int unsigned WORD_BITS    = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [47:0]                        s_axis_tdata,  // word_value, local_index, current_pc, saved_slot
    input  logic [2:0]                         s_axis_tuser,  // action
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [47:0]                        m_axis_tdata,  // read_word, restored_pc, slot_given, error_code
    input  logic                               i_cfg_we,
    input  logic [csfu_pkg::CfgIdxBits-1:0]    i_cfg_idx,
    input  logic [csfu_pkg::CfgDataBits-1:0]   i_cfg_data
);

    localparam int unsigned ADDR_W  = $clog2(STORE_WORDS);
    localparam int unsigned SLOT_AW = (RETURN_SLOTS > 1) ? $clog2(RETURN_SLOTS) : 1;

    csfu_pkg::t_cfg           cfg;
    csfu_pkg::t_s1            s1;
    logic                     s1_valid;
    logic                     s1_adv;
    logic                     st_we, st_re;
    logic [ADDR_W-1:0]        st_waddr, st_raddr;
    logic [WORD_BITS-1:0]     st_wdata, st_rdata;
    logic                     rt_we, rt_re;
    logic [SLOT_AW-1:0]       rt_waddr, rt_raddr;
    logic [15:0]              rt_wdata, rt_rdata;

    csfu_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    csfu_ctrl #(
        .STORE_WORDS  (STORE_WORDS),
        .RETURN_SLOTS (RETURN_SLOTS),
        .WORD_BITS    (WORD_BITS),
        .ADDR_W       (ADDR_W),
        .SLOT_AW      (SLOT_AW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_req_valid   (s_axis_tvalid),
        .o_req_ready   (s_axis_tready),
        .i_action      (s_axis_tuser),
        .i_word_value  (s_axis_tdata[15:0]),
        .i_local_index (s_axis_tdata[23:16]),
        .i_current_pc  (s_axis_tdata[39:24]),
        .i_saved_slot  (s_axis_tdata[47:40]),
        .i_s1_adv      (s1_adv),
        .o_s1_valid    (s1_valid),
        .o_s1          (s1),
        .o_st_we       (st_we),
        .o_st_waddr    (st_waddr),
        .o_st_wdata    (st_wdata),
        .o_st_re       (st_re),
        .o_st_raddr    (st_raddr),
        .o_rt_we       (rt_we),
        .o_rt_waddr    (rt_waddr),
        .o_rt_wdata    (rt_wdata),
        .o_rt_re       (rt_re),
        .o_rt_raddr    (rt_raddr)
    );

    csfu_ram #(
        .DEPTH (STORE_WORDS),
        .AW    (ADDR_W),
        .DW    (WORD_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    csfu_ram #(
        .DEPTH (RETURN_SLOTS),
        .AW    (SLOT_AW),
        .DW    (16)
    ) u_rtab (
        .i_clk   (i_clk),
        .i_we    (rt_we),
        .i_waddr (rt_waddr),
        .i_wdata (rt_wdata),
        .i_re    (rt_re),
        .i_raddr (rt_raddr),
        .o_rdata (rt_rdata)
    );

    csfu_out #(
        .WORD_BITS (WORD_BITS)
    ) u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (s1_valid),
        .i_s1       (s1),
        .i_st_rdata (st_rdata),
        .i_rt_rdata (rt_rdata),
        .o_s1_adv   (s1_adv),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (m_axis_tdata)
    );

    a_err_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[42:40] != csfu_pkg::ERR_OK)
        |-> (m_axis_tdata[39:0] == 40'd0))
        else $error("error result carries nonzero data");

    a_err_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[42:40] <= csfu_pkg::ERR_RANGE)
            && (m_axis_tdata[47:43] == 5'd0))
        else $error("result error code out of range");

    a_one_store_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({st_we, st_re, rt_we, rt_re}) <= 1)
        else $error("more than one memory access for one request");

    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_valid && !m_axis_tvalid |=> m_axis_tvalid)
        else $error("first stage did not move into an empty output register");

endmodule

@@ tb/sv/checked_stack_frame_unit_core_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for checked_stack_frame_unit_core: directed and random requests,
// random idling on both stream sides and a scoreboard that predicts every result.
// Depends on csfu_pkg and the checked_stack_frame_unit_core RTL.
module checked_stack_frame_unit_core_tb;
    import csfu_pkg::*;

    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam int unsigned STORE_WORDS = 256;
    localparam int unsigned RETURN_SLOTS = 16;
    localparam int unsigned ITEMS_PER_SETUP = 200;

    typedef struct {
        logic [15:0] read_word;
        logic [15:0] restored_pc;
        logic [7:0]  slot_given;
        t_err        error_code;
    } t_frame_result;

    typedef struct {
        logic [7:0] fb;
        logic [8:0] ob;
        logic [8:0] se;
        bit         bc;
        bit         rc;
        bit         calm;
    } t_frame_setup;

    class frame_scoreboard;
        logic [15:0]   words [STORE_WORDS];
        bit            written [STORE_WORDS];
        logic [8:0]    top;
        logic [15:0]   ret_pc [RETURN_SLOTS];
        bit            ret_used [RETURN_SLOTS];
        int unsigned   ret_count;
        logic [7:0]    frame_base;
        logic [8:0]    operand_base;
        logic [8:0]    stack_end;
        bit            bound_on;
        bit            reuse_on;
        t_frame_result awaited [$];
        int unsigned   errors;

        function new();
            foreach (written[i]) written[i] = 1'b0;
            foreach (ret_used[i]) ret_used[i] = 1'b0;
            top = '0;
            ret_count = 0;
            frame_base = '0;
            operand_base = '0;
            stack_end = 9'd256;
            bound_on = 1'b1;
            reuse_on = 1'b1;
            errors = 0;
        endfunction

        function void apply_config(t_cfg_idx idx, logic [8:0] value);
            case (idx)
                CFG_FRAME_BASE: frame_base = value[7:0];
                CFG_OPERAND_BASE: begin
                    operand_base = value;
                    top = value;
                end
                CFG_STACK_END: stack_end = value;
                CFG_BOUND_CHECKS: bound_on = value[0];
                CFG_REUSE_CHECKS: reuse_on = value[0];
                default: ;
            endcase
        endfunction

        function logic [8:0] local_addr(logic [7:0] idx);
            return {1'b0, frame_base} + {1'b0, idx};
        endfunction

        function bit pop_ok();
            return !(bound_on && top <= operand_base);
        endfunction

        function bit local_ok(logic [7:0] idx);
            return !(bound_on && local_addr(idx) >= operand_base);
        endfunction

        function void note_request(logic [2:0] act, logic [47:0] data);
            logic [15:0]   w;
            logic [7:0]    li;
            logic [15:0]   pc;
            logic [7:0]    sl;
            logic [8:0]    loc;
            t_frame_result r;
            w = data[15:0];
            li = data[23:16];
            pc = data[39:24];
            sl = data[47:40];
            loc = local_addr(li);
            r = '{16'h0, 16'h0, 8'h0, ERR_OK};
            case (act)
                ACT_PUSH: begin
                    if (bound_on && top >= stack_end) begin
                        r.error_code = ERR_OVERFLOW;
                    end else begin
                        words[top[7:0]] = w;
                        written[top[7:0]] = 1'b1;
                        top = top + 9'd1;
                    end
                end
                ACT_POP: begin
                    if (!pop_ok()) begin
                        r.error_code = ERR_UNDERFLOW;
                    end else begin
                        top = top - 9'd1;
                        r.read_word = words[top[7:0]];
                    end
                end
                ACT_READ_LOCAL: begin
                    if (!local_ok(li)) r.error_code = ERR_OVERFLOW;
                    else r.read_word = words[loc[7:0]];
                end
                ACT_WRITE_LOCAL: begin
                    if (!local_ok(li)) begin
                        r.error_code = ERR_OVERFLOW;
                    end else begin
                        words[loc[7:0]] = w;
                        written[loc[7:0]] = 1'b1;
                    end
                end
                ACT_SAVE_PC: begin
                    if (ret_count >= RETURN_SLOTS) begin
                        r.error_code = ERR_RANGE;
                    end else begin
                        ret_pc[ret_count] = pc;
                        ret_used[ret_count] = 1'b0;
                        r.slot_given = ret_count[7:0];
                        ret_count++;
                    end
                end
                ACT_RESTORE_PC: begin
                    if (sl >= ret_count) begin
                        r.error_code = ERR_RANGE;
                    end else if (reuse_on && ret_used[sl]) begin
                        r.error_code = ERR_REUSE;
                    end else begin
                        ret_used[sl] = 1'b1;
                        r.restored_pc = ret_pc[sl];
                    end
                end
                default: ;
            endcase
            awaited.insert(awaited.size(), r);
        endfunction

        function void check_result(logic [47:0] data);
            t_frame_result r;
            if (awaited.size() == 0) begin
                $error("result %h arrived with no request outstanding", data);
                errors++;
                return;
            end
            r = awaited.pop_front();
            if (data[15:0] !== r.read_word) begin
                $error("read_word mismatch: expected %h, got %h", r.read_word, data[15:0]);
                errors++;
            end
            if (data[31:16] !== r.restored_pc) begin
                $error("restored_pc mismatch: expected %h, got %h", r.restored_pc,
                       data[31:16]);
                errors++;
            end
            if (data[39:32] !== r.slot_given) begin
                $error("slot_given mismatch: expected %h, got %h", r.slot_given, data[39:32]);
                errors++;
            end
            if (data[42:40] !== r.error_code) begin
                $error("error_code mismatch: expected %h, got %h", r.error_code, data[42:40]);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // word_value, local_index, current_pc, saved_slot
    logic [2:0]  s_axis_tuser = '0;   // action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // read_word, restored_pc, slot_given, error_code
    logic        i_cfg_we = 1'b0;
    logic [CfgIdxBits-1:0]  i_cfg_idx = '0;
    logic [CfgDataBits-1:0] i_cfg_data = '0;

    bit quiet = 1'b0;
    frame_scoreboard sb;

    t_frame_setup setups [7] = '{
        '{8'd0,   9'd64,  9'd128, 1'b1, 1'b1, 1'b1},
        '{8'd200, 9'd256, 9'd256, 1'b1, 1'b0, 1'b0},
        '{8'd255, 9'd0,   9'd256, 1'b0, 1'b1, 1'b0},
        '{8'd0,   9'd256, 9'd0,   1'b1, 1'b1, 1'b0},
        '{8'd128, 9'd200, 9'd256, 1'b1, 1'b1, 1'b0},
        '{8'd0,   9'd256, 9'd0,   1'b0, 1'b0, 1'b0},
        '{8'd0,   9'd0,   9'd200, 1'b1, 1'b1, 1'b0}
    };

    always #4 i_clk = ~i_clk;

    checked_stack_frame_unit_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    function automatic logic [47:0] pack_req(logic [15:0] w, logic [7:0] li, logic [15:0] pc,
                                             logic [7:0] sl);
        return {sl, pc, li, w};
    endfunction

    task automatic program_frame(input t_frame_setup s);
        t_cfg_idx   regs [5];
        logic [8:0] vals [5];
        regs = '{CFG_FRAME_BASE, CFG_OPERAND_BASE, CFG_STACK_END, CFG_BOUND_CHECKS,
                 CFG_REUSE_CHECKS};
        vals = '{{1'b0, s.fb}, s.ob, s.se, {8'd0, s.bc}, {8'd0, s.rc}};
        for (int i = 0; i < 5; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= regs[i];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            sb.apply_config(regs[i], vals[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_request(input logic [2:0] act, input logic [47:0] data);
        while (!quiet && $urandom_range(0, 99) < 15) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= data;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(act, data);
    endtask

    task automatic make_request(output logic [2:0] act, output logic [47:0] data);
        int unsigned pick;
        logic [7:0]  li;
        logic [7:0]  sl;
        logic [8:0]  span;
        logic [8:0]  loc;
        logic [8:0]  below;
        pick = $urandom_range(0, 99);
        if (pick < 3) act = ($urandom_range(0, 1) != 0) ? ACT_SPARE_HI : ACT_SPARE_LO;
        else if (pick < 28) act = ACT_PUSH;
        else if (pick < 53) act = ACT_POP;
        else if (pick < 68) act = ACT_READ_LOCAL;
        else if (pick < 83) act = ACT_WRITE_LOCAL;
        else if (pick < 88) act = ACT_SAVE_PC;
        else act = ACT_RESTORE_PC;
        li = 8'($urandom_range(0, 255));
        if (sb.operand_base > {1'b0, sb.frame_base} && $urandom_range(0, 9) < 7) begin
            span = sb.operand_base - {1'b0, sb.frame_base};
            li = 8'($urandom_range(0, span - 1));
        end
        sl = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 17))
                                         : 8'($urandom_range(0, 255));
        loc = sb.local_addr(li);
        below = sb.top - 9'd1;
        // Never read a word that has not been written yet.
        if (act == ACT_POP && sb.pop_ok() && !sb.written[below[7:0]]) act = ACT_PUSH;
        if (act == ACT_READ_LOCAL && sb.local_ok(li) && !sb.written[loc[7:0]])
            act = ACT_WRITE_LOCAL;
        data = pack_req(16'($urandom_range(0, 65535)), li, 16'($urandom_range(0, 65535)), sl);
    endtask

    task automatic wait_drained();
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic directed_requests();
        send_request(ACT_WRITE_LOCAL, pack_req(16'h7FFF, 8'd0, 16'h0, 8'd0));
        send_request(ACT_WRITE_LOCAL, pack_req(16'h8000, 8'd15, 16'h0, 8'd0));
        send_request(ACT_READ_LOCAL, pack_req(16'h0, 8'd0, 16'h0, 8'd0));
        send_request(ACT_READ_LOCAL, pack_req(16'h0, 8'd15, 16'h0, 8'd0));
        send_request(ACT_READ_LOCAL, pack_req(16'h0, 8'd16, 16'h0, 8'd0));
        send_request(ACT_WRITE_LOCAL, pack_req(16'hFFFF, 8'd255, 16'h0, 8'd0));
        send_request(ACT_PUSH, pack_req(16'hFFFF, 8'd0, 16'h0, 8'd0));
        send_request(ACT_PUSH, pack_req(16'h0000, 8'd0, 16'h0, 8'd0));
        send_request(ACT_PUSH, pack_req(16'h1234, 8'd0, 16'h0, 8'd0));
        send_request(ACT_POP, pack_req(16'h0, 8'd0, 16'h0, 8'd0));
        send_request(ACT_POP, pack_req(16'h0, 8'd0, 16'h0, 8'd0));
        send_request(ACT_POP, pack_req(16'h0, 8'd0, 16'h0, 8'd0));
        send_request(ACT_SAVE_PC, pack_req(16'h0, 8'd0, 16'hFFFF, 8'd0));
        send_request(ACT_SAVE_PC, pack_req(16'h0, 8'd0, 16'h0000, 8'd0));
        send_request(ACT_RESTORE_PC, pack_req(16'h0, 8'd0, 16'h0, 8'd0));
        send_request(ACT_RESTORE_PC, pack_req(16'h0, 8'd0, 16'h0, 8'd0));
        send_request(ACT_RESTORE_PC, pack_req(16'h0, 8'd0, 16'h0, 8'd2));
        send_request(ACT_RESTORE_PC, pack_req(16'h0, 8'd0, 16'h0, 8'd255));
        send_request(ACT_SPARE_LO, {48{1'b1}});
        send_request(ACT_SPARE_HI, {48{1'b1}});
        s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
            m_axis_tready <= quiet || ($urandom_range(0, 99) >= 15);
        end
    end

    initial begin
        logic [2:0]  act;
        logic [47:0] data;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        program_frame('{8'd0, 9'd16, 9'd18, 1'b1, 1'b1, 1'b0});
        directed_requests();
        wait_drained();
        foreach (setups[k]) begin
            program_frame(setups[k]);
            quiet = setups[k].calm;
            repeat (ITEMS_PER_SETUP) begin
                make_request(act, data);
                send_request(act, data);
            end
            s_axis_tvalid <= 1'b0;
            quiet = 1'b0;
            wait_drained();
        end
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("checked_stack_frame_unit_core test passed");
        end else begin
            $display("checked_stack_frame_unit_core test failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("checked_stack_frame_unit_core test failed");
        $finish;
    end

endmodule
